// ----- hdl/mnpl_pkg.sv -----
// ----------------------------------------------------------------------------
// mnpl_pkg
// Shared types and constants of the monophonic note priority block.
// ----------------------------------------------------------------------------
package mnpl_pkg;

    localparam logic [7:0] NONE_NOTE = 8'hFF;
    localparam logic [4:0] HELD_MAX  = 5'd31;

    typedef enum logic [1:0] {
        MODE_ON       = 2'd0,
        MODE_OFF      = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_RESELECT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NOTE_ON   = 2'd0,
        KIND_NOTE_OFF  = 2'd1,
        KIND_CHANGE    = 2'd2,
        KIND_RETRIGGER = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PRIO_LAST    = 2'd0,
        PRIO_HIGHEST = 2'd1,
        PRIO_LOWEST  = 2'd2,
        PRIO_FIRST   = 2'd3
    } prio_t;

    typedef enum logic [1:0] {
        CFG_ENABLED   = 2'd0,
        CFG_PRIORITY  = 2'd1,
        CFG_RETRIGGER = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND,
        ST_PICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [31:0] order;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan_find;
        logic scan_pick;
        logic write_new;
        logic write_vel;
        logic release_slot;
        logic apply_pick;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic  track_ok;
        mode_t mode;
        logic  enabled;
        logic  retrig;
        logic  found;
        logic  hit;
        logic  scan_done;
    } dp_status_t;

    typedef struct packed {
        logic       pass_through;
        logic       event_valid;
        kind_t      event_kind;
        logic [6:0] event_note;
        logic [6:0] event_velocity;
        logic [3:0] event_channel;
        logic [7:0] event_prev_note;
        logic       event_legato;
        logic [7:0] sounding_note;
        logic [4:0] held_count;
    } result_t;

endpackage

// ----- hdl/mnpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// mnpl_ctrl
// Sequencer that steps one item through table search, update and selection.
// ----------------------------------------------------------------------------
module mnpl_ctrl
    import mnpl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.track_ok) begin
                    state_next = ST_DONE;
                end else begin
                    unique case (status.mode) inside
                        MODE_ON, MODE_OFF: begin
                            if (status.enabled) begin
                                cmd.scan_find = 1'b1;
                                state_next    = ST_FIND;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_RESELECT: begin
                            cmd.scan_pick = 1'b1;
                            state_next    = ST_PICK;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (status.scan_done) begin
                    if (status.mode == MODE_ON) begin
                        if (status.found) begin
                            cmd.write_vel = 1'b1;
                            if (status.hit && status.retrig) begin
                                state_next = ST_DONE;
                            end else begin
                                cmd.scan_pick = 1'b1;
                                state_next    = ST_PICK;
                            end
                        end else begin
                            cmd.write_new = 1'b1;
                            cmd.scan_pick = 1'b1;
                            state_next    = ST_PICK;
                        end
                    end else if (status.found) begin
                        cmd.release_slot = 1'b1;
                        if (status.hit) begin
                            cmd.scan_pick = 1'b1;
                            state_next    = ST_PICK;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PICK: begin
                if (status.scan_done) begin
                    cmd.apply_pick = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mnpl_dp.sv -----
// ----------------------------------------------------------------------------
// mnpl_dp
// Note table memory, held bits, per-track state, slot scan unit and result.
// ----------------------------------------------------------------------------
module mnpl_dp
    import mnpl_pkg::*;
#(
    parameter int TRACKS = 4,
    parameter int SLOTS  = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    input  logic [1:0] in_mode,
    input  logic [1:0] in_track,
    input  logic [6:0] in_note,
    input  logic [6:0] in_velocity,
    input  logic [3:0] in_channel,
    input  logic [3:0] enabled_mask,
    input  logic [7:0] priority_modes,
    input  logic [3:0] retrigger_mask,
    output dp_status_t status,
    output result_t    res
);

    localparam int ENTRIES = TRACKS * SLOTS;
    localparam int AW      = $clog2(ENTRIES);
    localparam int SW      = $clog2(SLOTS);
    localparam int TW      = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    mode_t      mode_reg;
    logic [1:0] track_reg;
    logic [6:0] note_reg;
    logic [6:0] vel_reg;
    logic [3:0] ch_reg;
    logic       hit_reg;
    logic [7:0] prev_reg;

    entry_t     mem [ENTRIES];
    entry_t     rd_data_reg;
    logic [ENTRIES-1:0] held_reg;

    logic [4:0]  ht_reg       [TRACKS];
    logic [7:0]  cur_note_reg [TRACKS];
    logic [6:0]  cur_vel_reg  [TRACKS];
    logic [3:0]  cur_ch_reg   [TRACKS];
    logic [31:0] press_reg    [TRACKS];

    logic          scan_act_reg;
    logic          rd_pend_reg;
    logic          pick_kind_reg;
    logic [SW-1:0] cnt_reg;
    logic [SW-1:0] rd_idx_reg;

    logic          found_reg;
    logic [SW-1:0] found_idx_reg;
    logic [31:0]   found_ord_reg;
    logic          free_reg;
    logic [SW-1:0] free_idx_reg;
    logic [SW-1:0] old_idx_reg;
    logic [31:0]   old_ord_reg;
    logic          best_reg;
    logic [6:0]    best_note_reg;
    logic [6:0]    best_vel_reg;
    logic [3:0]    best_ch_reg;
    logic [31:0]   best_ord_reg;

    logic [TW-1:0] trk;
    logic [31:0]   base_full;
    logic [AW-1:0] base;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] proc_addr;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] new_slot;
    logic          wr_en;
    entry_t        wr_data;
    logic          track_ok;
    logic          en;
    logic          retrig;
    prio_t         prio;
    logic          proc_held;
    logic          take;
    logic [7:0]    cur_note;
    logic [6:0]    cur_vel;
    logic [3:0]    cur_ch;
    logic [4:0]    ht;

    assign trk       = TW'(track_reg);
    assign base_full = 32'(trk) * 32'(SLOTS);
    assign base      = base_full[AW-1:0];
    assign rd_addr   = base + AW'(cnt_reg);
    assign proc_addr = base + AW'(rd_idx_reg);
    assign track_ok  = 32'(track_reg) < 32'(TRACKS);
    assign en        = enabled_mask[track_reg];
    assign retrig    = retrigger_mask[track_reg];
    assign prio      = prio_t'(priority_modes[{track_reg, 1'b0} +: 2]);
    assign proc_held = held_reg[proc_addr];
    assign cur_note  = cur_note_reg[trk];
    assign cur_vel   = cur_vel_reg[trk];
    assign cur_ch    = cur_ch_reg[trk];
    assign ht        = ht_reg[trk];
    assign new_slot  = free_reg ? free_idx_reg : old_idx_reg;

    always_comb begin
        wr_en   = cmd.write_new || cmd.write_vel;
        wr_addr = base + AW'(cmd.write_new ? new_slot : found_idx_reg);
        wr_data.note     = note_reg;
        wr_data.velocity = vel_reg;
        wr_data.channel  = ch_reg;
        wr_data.order    = cmd.write_new ? press_reg[trk] : found_ord_reg;
    end

    always_comb begin
        if (!best_reg) begin
            take = 1'b1;
        end else begin
            case (prio)
                PRIO_LAST:    take = rd_data_reg.order >= best_ord_reg;
                PRIO_HIGHEST: take = rd_data_reg.note >= best_note_reg;
                PRIO_LOWEST:  take = rd_data_reg.note < best_note_reg;
                default:      take = rd_data_reg.order < best_ord_reg;
            endcase
        end
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (scan_act_reg) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-track state and scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            scan_act_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
            for (int t = 0; t < TRACKS; t++) begin
                ht_reg[t]       <= '0;
                cur_note_reg[t] <= NONE_NOTE;
                cur_vel_reg[t]  <= '0;
                cur_ch_reg[t]   <= '0;
                press_reg[t]    <= '0;
            end
        end else begin
            if (cmd.scan_find || cmd.scan_pick) begin
                scan_act_reg <= 1'b1;
                rd_pend_reg  <= 1'b0;
            end else if (scan_act_reg) begin
                rd_pend_reg <= 1'b1;
                if (cnt_reg == SW'(SLOTS - 1)) begin
                    scan_act_reg <= 1'b0;
                end
            end else begin
                rd_pend_reg <= 1'b0;
            end
            if (cmd.write_new) begin
                held_reg[wr_addr] <= 1'b1;
                press_reg[trk]    <= press_reg[trk] + 32'd1;
                if (free_reg && ht < HELD_MAX) begin
                    ht_reg[trk] <= ht + 5'd1;
                end
            end
            if (cmd.release_slot) begin
                held_reg[base + AW'(found_idx_reg)] <= 1'b0;
                if (ht != 5'd0) begin
                    ht_reg[trk] <= ht - 5'd1;
                end
            end
            if (cmd.apply_pick) begin
                if (ht == 5'd0) begin
                    cur_note_reg[trk] <= NONE_NOTE;
                    cur_vel_reg[trk]  <= '0;
                end else if (best_reg) begin
                    cur_note_reg[trk] <= {1'b0, best_note_reg};
                    cur_vel_reg[trk]  <= best_vel_reg;
                    cur_ch_reg[trk]   <= best_ch_reg;
                end
            end
            if (cmd.finish && track_ok && mode_reg == MODE_CLEAR) begin
                for (int i = 0; i < SLOTS; i++) begin
                    held_reg[base + AW'(i)] <= 1'b0;
                end
                ht_reg[trk]       <= '0;
                cur_note_reg[trk] <= NONE_NOTE;
                cur_vel_reg[trk]  <= '0;
            end
        end
    end

    // item capture and scan accumulators
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= mode_t'(in_mode);
            track_reg <= in_track;
            note_reg  <= in_note;
            vel_reg   <= in_velocity;
            ch_reg    <= in_channel;
            found_reg <= 1'b0;
        end
        if (cmd.scan_find || cmd.scan_pick) begin
            cnt_reg       <= '0;
            pick_kind_reg <= cmd.scan_pick;
            best_reg      <= 1'b0;
        end else if (scan_act_reg) begin
            rd_idx_reg <= cnt_reg;
            cnt_reg    <= cnt_reg + SW'(1);
        end
        if (cmd.scan_find) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            hit_reg   <= cur_note == {1'b0, note_reg};
            prev_reg  <= cur_note;
        end
        if (rd_pend_reg && !pick_kind_reg) begin
            if (proc_held && !found_reg && rd_data_reg.note == note_reg
                    && rd_data_reg.channel == ch_reg) begin
                found_reg     <= 1'b1;
                found_idx_reg <= rd_idx_reg;
                found_ord_reg <= rd_data_reg.order;
            end
            if (!proc_held && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_idx_reg == '0 || rd_data_reg.order < old_ord_reg) begin
                old_idx_reg <= rd_idx_reg;
                old_ord_reg <= rd_data_reg.order;
            end
        end
        if (rd_pend_reg && pick_kind_reg && proc_held && take) begin
            best_reg      <= 1'b1;
            best_note_reg <= rd_data_reg.note;
            best_vel_reg  <= rd_data_reg.velocity;
            best_ch_reg   <= rd_data_reg.channel;
            best_ord_reg  <= rd_data_reg.order;
        end
    end

    always_comb begin
        status.track_ok  = track_ok;
        status.mode      = mode_reg;
        status.enabled   = en;
        status.retrig    = retrig;
        status.found     = found_reg;
        status.hit       = hit_reg;
        status.scan_done = !scan_act_reg && !rd_pend_reg;
    end

    always_comb begin
        res                 = '0;
        res.event_kind      = KIND_NOTE_ON;
        res.event_prev_note = NONE_NOTE;
        res.sounding_note   = cur_note;
        res.held_count      = ht;
        if (!track_ok) begin
            res.pass_through  = 1'b1;
            res.sounding_note = NONE_NOTE;
            res.held_count    = '0;
        end else begin
            unique case (mode_reg)
                MODE_ON: begin
                    if (!en) begin
                        res.pass_through = 1'b1;
                    end else if (found_reg) begin
                        if (hit_reg && retrig) begin
                            res.pass_through    = 1'b1;
                            res.event_valid     = 1'b1;
                            res.event_kind      = KIND_RETRIGGER;
                            res.event_note      = note_reg;
                            res.event_velocity  = vel_reg;
                            res.event_channel   = ch_reg;
                            res.event_prev_note = {1'b0, note_reg};
                        end
                    end else if (cur_note != prev_reg) begin
                        res.event_valid     = 1'b1;
                        res.event_note      = cur_note[6:0];
                        res.event_velocity  = cur_vel;
                        res.event_channel   = cur_ch;
                        if (prev_reg == NONE_NOTE) begin
                            res.event_kind   = KIND_NOTE_ON;
                            res.pass_through = 1'b1;
                        end else begin
                            res.event_kind      = KIND_CHANGE;
                            res.event_prev_note = prev_reg;
                            res.event_legato    = !retrig;
                            res.pass_through    = retrig;
                        end
                    end
                end
                MODE_OFF: begin
                    if (!en) begin
                        res.pass_through = 1'b1;
                    end else if (found_reg && hit_reg) begin
                        res.event_valid     = 1'b1;
                        res.event_channel   = cur_ch;
                        res.event_prev_note = prev_reg;
                        if (cur_note == NONE_NOTE) begin
                            res.event_kind   = KIND_NOTE_OFF;
                            res.event_note   = prev_reg[6:0];
                            res.pass_through = 1'b1;
                        end else begin
                            res.event_kind     = KIND_CHANGE;
                            res.event_note     = cur_note[6:0];
                            res.event_velocity = cur_vel;
                            res.event_legato   = !retrig;
                        end
                    end
                end
                MODE_CLEAR: begin
                    if (cur_note != NONE_NOTE) begin
                        res.event_valid     = 1'b1;
                        res.event_kind      = KIND_NOTE_OFF;
                        res.event_note      = cur_note[6:0];
                        res.event_channel   = cur_ch;
                        res.event_prev_note = cur_note;
                    end
                    res.sounding_note = NONE_NOTE;
                    res.held_count    = '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/mono_note_priority_legato.sv -----
// ----------------------------------------------------------------------------
// mono_note_priority_legato
// Per-track monophonic note selector with last, highest, lowest and first
// priority, legato and retrigger handling and oldest-note stealing.
// ----------------------------------------------------------------------------
// One item is handled at a time. A note on for a new note makes two passes
// over the track's slots between transfer and result: one pass to look
// the note up and find a free or oldest slot, and a second pass to
// choose the sounding note, each pass one slot per cycle through the single
// read port of the note table. Note off, retrigger and reselect take one or
// two passes; clear and disabled tracks skip both passes. The result
// sits in an output register, so the next item is taken while it waits.
module mono_note_priority_legato
    import mnpl_pkg::*;
#(
    parameter int TRACKS = 4,
    parameter int SLOTS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // note[6:0], velocity[13:7], channel[17:14]
    input  logic [3:0]  s_tuser,  // mode[1:0], track[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_note, event_velocity, event_channel, event_prev_note,
    // event_legato, sounding_note, held_count
    output logic [39:0] m_tdata,
    output logic [3:0]  m_tuser   // pass_through, event_valid, event_kind[1:0]
);

    logic [3:0] enabled_reg;
    logic [7:0] priority_reg;
    logic [3:0] retrigger_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       out_free;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= '0;
            priority_reg  <= '0;
            retrigger_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ENABLED:   enabled_reg   <= cfg_wdata[3:0];
                CFG_PRIORITY:  priority_reg  <= cfg_wdata;
                CFG_RETRIGGER: retrigger_reg <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= res;
        end
    end

    mnpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    mnpl_dp #(
        .TRACKS (TRACKS),
        .SLOTS  (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_mode        (s_tuser[1:0]),
        .in_track       (s_tuser[3:2]),
        .in_note        (s_tdata[6:0]),
        .in_velocity    (s_tdata[13:7]),
        .in_channel     (s_tdata[17:14]),
        .enabled_mask   (enabled_reg),
        .priority_modes (priority_reg),
        .retrigger_mask (retrigger_reg),
        .status         (status),
        .res            (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.held_count, out_reg.sounding_note, out_reg.event_legato,
                       out_reg.event_prev_note, out_reg.event_channel,
                       out_reg.event_velocity, out_reg.event_note};
    assign m_tuser  = {out_reg.event_kind, out_reg.event_valid, out_reg.pass_through};

endmodule
